// ===== rtl/core/yuvmb_pkg.sv =====
`default_nettype none

package yuvmb_pkg;

  // largest frame in macroblocks
  localparam int MAX_MB_COLS = 8;
  localparam int MAX_MB_ROWS = 8;

  // bytes per macroblock: 256 luma, 64 cb, 64 cr
  localparam int MB_BYTES   = 384;
  localparam int LUMA_BYTES = 256;
  localparam int CB_END     = 320;

  localparam int STORE_DEPTH = MAX_MB_COLS * MAX_MB_ROWS * MB_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths fixed by the interface
  localparam int DIM_W   = 4;
  localparam int MB_W    = 6;
  localparam int OFS_W   = 9;
  localparam int NMB_W   = 2 * DIM_W;
  localparam int COL_W   = (MAX_MB_COLS > 1) ? $clog2(MAX_MB_COLS) : 1;
  localparam int ROW_W   = (MAX_MB_ROWS > 1) ? $clog2(MAX_MB_ROWS) : 1;
  localparam int LINE_W  = ROW_W + 4;
  localparam int XPOS_W  = COL_W + 4;
  localparam int STRD_W  = DIM_W + 4;
  localparam int PROD_W  = LINE_W + STRD_W;
  localparam int CNT_W   = ADDR_W + 1;

  // input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // plane codes
  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_t;

  // register value zero reads as one, anything above the limit saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] d;
    d = (v == '0) ? DIM_W'(1) : v;
    if (d > maxv) d = maxv;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/yuv420_macroblock_reorder.sv =====
// path: a beat's result is held in the read stage, then in the output register, before it reaches the master side
// throughput: one beat per cycle, loads and fetches alike, unless the master side stalls;
//   set by the single port of the frame memory, which takes one write or one read a cycle
// reset: synchronous, active high; clears counters, flags and pipeline valids, and sets
//   both frame dimensions to eight macroblocks; the frame memory is not cleared
`default_nettype none

module yuv420_macroblock_reorder
  import yuvmb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sample_byte
  input  wire logic        s_tuser,   // [0] command

  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [5:0] macroblock number, [13:6] block_offset,
                                      // [21:14] sample, [23:22] zero
  output logic [3:0]       m_tuser,   // [0] valid_res, [2:1] plane, [3] last_of_mb
  output logic             m_tlast,   // last_of_frame

  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [DIM_W-1:0] frame_width_mbs;
  logic [DIM_W-1:0] frame_height_mbs;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width_mbs  <= DIM_W'(MAX_MB_COLS);
      frame_height_mbs <= DIM_W'(MAX_MB_ROWS);
    end else if (cfg_write) begin
      if (paddr[2] == REG_WIDTH) begin
        frame_width_mbs <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_MB_COLS));
      end else begin
        frame_height_mbs <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_MB_ROWS));
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HEIGHT) begin
      prdata = {{(32-DIM_W){1'b0}}, frame_height_mbs};
    end else begin
      prdata = {{(32-DIM_W){1'b0}}, frame_width_mbs};
    end
  end

  // ---------------------------------------------------------------
  // frame geometry, derived from the registers
  // ---------------------------------------------------------------
  logic [NMB_W-1:0]  num_mbs;
  logic [CNT_W-1:0]  total_bytes;
  logic [ADDR_W-1:0] cb_base;
  logic [ADDR_W-1:0] cr_base;

  assign num_mbs     = frame_width_mbs * frame_height_mbs;
  // 384 = 256 + 128, 320 = 256 + 64
  assign total_bytes = CNT_W'({num_mbs, 8'b0}) + CNT_W'({num_mbs, 7'b0});
  assign cb_base     = ADDR_W'({num_mbs, 8'b0});
  assign cr_base     = ADDR_W'({num_mbs, 8'b0}) + ADDR_W'({num_mbs, 6'b0});

  // ---------------------------------------------------------------
  // load / drain control
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] load_count;
  logic             frame_full;
  logic [MB_W-1:0]  drain_mb;
  logic [COL_W-1:0] drain_col;
  logic [ROW_W-1:0] drain_row;
  logic [OFS_W-1:0] drain_offset;

  logic             s_beat;
  logic             is_load;
  logic             load_we;
  logic             rd_en;
  logic             last_mb;
  logic             last_col;
  logic             last_fr;
  logic [CNT_W-1:0] load_count_next;

  assign s_beat   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == CMD_LOAD);
  assign load_we  = s_beat && is_load && !frame_full;
  assign rd_en    = s_beat && (s_tuser == CMD_FETCH) && frame_full;

  assign last_mb  = (drain_offset == OFS_W'(MB_BYTES - 1));
  assign last_col = (DIM_W'(drain_col) == frame_width_mbs - DIM_W'(1));
  assign last_fr  = last_mb && last_col &&
                    (DIM_W'(drain_row) == frame_height_mbs - DIM_W'(1));

  assign load_count_next = load_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      load_count   <= '0;
      frame_full   <= 1'b0;
      drain_mb     <= '0;
      drain_col    <= '0;
      drain_row    <= '0;
      drain_offset <= '0;
    end else if (load_we) begin
      load_count <= load_count_next;
      if (load_count_next >= total_bytes) frame_full <= 1'b1;
    end else if (rd_en) begin
      if (last_mb) begin
        drain_offset <= '0;
        if (last_fr) begin
          // frame drained, ready for the next one
          load_count <= '0;
          frame_full <= 1'b0;
          drain_mb   <= '0;
          drain_col  <= '0;
          drain_row  <= '0;
        end else begin
          drain_mb <= drain_mb + MB_W'(1);
          if (last_col) begin
            drain_col <= '0;
            drain_row <= drain_row + ROW_W'(1);
          end else begin
            drain_col <= drain_col + COL_W'(1);
          end
        end
      end else begin
        drain_offset <= drain_offset + OFS_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // read address of the sample being drained
  // ---------------------------------------------------------------
  plane_t            cur_plane;
  logic [7:0]        cur_off;
  logic [LINE_W-1:0] line_y;
  logic [STRD_W-1:0] stride;
  logic [XPOS_W-1:0] xpos;
  logic [ADDR_W-1:0] base;
  logic [PROD_W-1:0] line_start;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (drain_offset < OFS_W'(LUMA_BYTES)) begin
      cur_plane = PLANE_Y;
      cur_off   = drain_offset[7:0];
    end else if (drain_offset < OFS_W'(CB_END)) begin
      cur_plane = PLANE_CB;
      cur_off   = 8'(drain_offset - OFS_W'(LUMA_BYTES));
    end else begin
      cur_plane = PLANE_CR;
      cur_off   = 8'(drain_offset - OFS_W'(CB_END));
    end

    case (cur_plane)
      PLANE_Y: begin
        line_y = {drain_row, 4'b0} + LINE_W'(cur_off[7:4]);
        stride = {frame_width_mbs, 4'b0};
        xpos   = {drain_col, 4'b0} + XPOS_W'(cur_off[3:0]);
        base   = '0;
      end
      PLANE_CB: begin
        line_y = LINE_W'({drain_row, 3'b0}) + LINE_W'(cur_off[5:3]);
        stride = STRD_W'({frame_width_mbs, 3'b0});
        xpos   = XPOS_W'({drain_col, 3'b0}) + XPOS_W'(cur_off[2:0]);
        base   = cb_base;
      end
      default: begin
        line_y = LINE_W'({drain_row, 3'b0}) + LINE_W'(cur_off[5:3]);
        stride = STRD_W'({frame_width_mbs, 3'b0});
        xpos   = XPOS_W'({drain_col, 3'b0}) + XPOS_W'(cur_off[2:0]);
        base   = cr_base;
      end
    endcase

    line_start = line_y * stride;
    rd_addr    = base + ADDR_W'(line_start) + ADDR_W'(xpos);
  end

  // ---------------------------------------------------------------
  // frame memory, single port, registered read
  // ---------------------------------------------------------------
  logic [7:0] frame_mem [STORE_DEPTH];
  logic [7:0] mem_q;

  always_ff @(posedge clk) begin
    if (load_we) frame_mem[load_count[ADDR_W-1:0]] <= s_tdata;
    if (rd_en) mem_q <= frame_mem[rd_addr];
  end

  // ---------------------------------------------------------------
  // pipeline: read stage, then output register
  // ---------------------------------------------------------------
  logic             s1_valid;
  logic             s1_vres;
  logic [MB_W-1:0]  s1_mb;
  logic [1:0]       s1_plane;
  logic [7:0]       s1_off;
  logic             s1_lmb;
  logic             s1_lfr;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // every beat yields one result; only a fetch of a full frame carries data
  always_ff @(posedge clk) begin
    if (s_beat) begin
      s1_vres <= rd_en;
      if (rd_en) begin
        s1_mb    <= drain_mb;
        s1_plane <= cur_plane;
        s1_off   <= cur_off;
        s1_lmb   <= last_mb;
        s1_lfr   <= last_fr;
      end else begin
        s1_mb    <= '0;
        s1_plane <= '0;
        s1_off   <= '0;
        s1_lmb   <= 1'b0;
        s1_lfr   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {2'b0, (s1_vres ? mem_q : 8'd0), s1_off, s1_mb};
      m_tuser <= {s1_lmb, s1_plane, s1_vres};
      m_tlast <= s1_lfr;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import yuvmb_pkg::*;

  // one result beat as the block should present it
  typedef struct {
    logic       valid_res;
    logic [5:0] mb_num;
    plane_t     plane;
    logic [7:0] block_offset;
    logic [7:0] sample;
    logic       last_of_mb;
    logic       last_of_frame;
  } mb_sample_t;

  // shadow of the frame store and drain counters, plus the samples still owed
  class mb_sample_predictor;
    logic [7:0]  frame_bytes [STORE_DEPTH];
    int unsigned cols, rows, loaded, mb, ofs;
    bit          full;
    mb_sample_t  due_samples [$];
    int unsigned mismatches;

    function new();
      cols = MAX_MB_COLS;
      rows = MAX_MB_ROWS;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      loaded = 0;
      full   = 0;
      mb     = 0;
      ofs    = 0;
    endfunction

    // register write: low nibble only, zero reads as one, saturates at the maximum
    function void write_dim(logic idx, logic [31:0] val);
      int unsigned d;
      d = val[3:0];
      if (d == 0) d = 1;
      if (idx == REG_WIDTH) begin
        if (d > MAX_MB_COLS) d = MAX_MB_COLS;
        cols = d;
      end else begin
        if (d > MAX_MB_ROWS) d = MAX_MB_ROWS;
        rows = d;
      end
      restart();
    endfunction

    // every accepted input beat owes exactly one result beat
    function void take_beat(logic cmd, logic [7:0] b);
      mb_sample_t  e;
      int unsigned nmb, row, col, o, addr;
      e.valid_res     = 1'b0;
      e.mb_num        = '0;
      e.plane         = PLANE_Y;
      e.block_offset  = '0;
      e.sample        = '0;
      e.last_of_mb    = 1'b0;
      e.last_of_frame = 1'b0;
      nmb = cols * rows;
      if (cmd == CMD_LOAD) begin
        // bytes arriving while the frame is complete are dropped
        if (!full) begin
          if (loaded < STORE_DEPTH) frame_bytes[loaded] = b;
          loaded++;
          if (loaded >= nmb * MB_BYTES) full = 1;
        end
      end else if (full) begin
        row = mb / cols;
        col = mb % cols;
        if (ofs < LUMA_BYTES) begin
          o = ofs;
          e.plane = PLANE_Y;
          addr = (row * 16 + o / 16) * cols * 16 + col * 16 + o % 16;
        end else if (ofs < CB_END) begin
          o = ofs - LUMA_BYTES;
          e.plane = PLANE_CB;
          addr = nmb * LUMA_BYTES + (row * 8 + o / 8) * cols * 8 + col * 8 + o % 8;
        end else begin
          o = ofs - CB_END;
          e.plane = PLANE_CR;
          addr = nmb * CB_END + (row * 8 + o / 8) * cols * 8 + col * 8 + o % 8;
        end
        e.valid_res     = 1'b1;
        e.mb_num        = 6'(mb);
        e.block_offset  = 8'(o);
        e.sample        = frame_bytes[addr];
        e.last_of_mb    = (ofs == MB_BYTES - 1);
        e.last_of_frame = e.last_of_mb && (mb + 1 >= nmb);
        if (e.last_of_mb) begin
          ofs = 0;
          if (e.last_of_frame) restart();
          else mb++;
        end else begin
          ofs++;
        end
      end
      due_samples.insert(due_samples.size(), e);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_sample(logic [23:0] tdata, logic [3:0] tuser, logic tlast);
      mb_sample_t e;
      if (due_samples.size() == 0) begin
        $error("result beat with no input beat waiting for it");
        mismatches++;
        return;
      end
      e = due_samples.pop_front();
      compare_field("valid_res",     8'(e.valid_res),     8'(tuser[0]));
      compare_field("mb_num",        8'(e.mb_num),        8'(tdata[5:0]));
      compare_field("plane",         8'(e.plane),         8'(tuser[2:1]));
      compare_field("block_offset",  e.block_offset,      tdata[13:6]);
      compare_field("sample",        e.sample,            tdata[21:14]);
      compare_field("last_of_mb",    8'(e.last_of_mb),    8'(tuser[3]));
      compare_field("last_of_frame", 8'(e.last_of_frame), 8'(tlast));
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;  // [7:0] sample_byte
  logic        s_tuser  = 1'b0; // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [5:0] macroblock number, [13:6] block_offset, [21:14] sample
  logic [3:0]  m_tuser;        // [0] valid_res, [2:1] plane, [3] last_of_mb
  logic        m_tlast;        // last_of_frame
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  mb_sample_predictor sb = new();

  // beats left in the current sender burst
  int unsigned burst_left = 0;

  yuv420_macroblock_reorder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one beat and hold it until taken; bursts of random length with
  // random gaps between them, now and then a long burst with no gaps
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                : $urandom_range(1, 24);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_beat(cmd, b);
  endtask

  // stop sending, let every owed result come back, then allow for the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.due_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup phase, then access phase until pready
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_dim(idx, val);
    @(posedge clk);
  endtask

  // one frame: fill the whole frame, then drain it in macroblock order; a few
  // beats carry the command that is wrong for the stage (fetch while filling,
  // load while draining); a cut-short frame stops at a random point
  task automatic run_frame(input int unsigned noise_pct, input bit cut_short);
    int unsigned total, done, stop_at;
    total   = sb.cols * sb.rows * MB_BYTES;
    stop_at = cut_short ? $urandom_range(1, 2 * total - 1) : 2 * total;
    done    = 0;
    while (done < stop_at) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat((done < total) ? CMD_FETCH : CMD_LOAD, 8'($urandom()));
      end else begin
        send_beat((done < total) ? CMD_LOAD : CMD_FETCH, 8'($urandom()));
        done++;
      end
    end
  endtask

  // result side: ready runs and stalls of random length, a long run now and
  // then, and two long hold-offs while the frame streams in so the block
  // backs up and stalls its input
  initial begin : result_sink
    int unsigned cyc, run_left, hold_left;
    bit          ready_now;
    cyc       = 0;
    run_left  = 0;
    hold_left = 0;
    ready_now = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_left != 0) begin
        hold_left--;
        ready_now = 1'b0;
      end else if (cyc == 200 || cyc == 700) begin
        hold_left = 400;
        ready_now = 1'b0;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        ready_now = !ready_now;
        if (ready_now)
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                  : $urandom_range(0, 20);
        else
          run_left = $urandom_range(0, 5);
      end
      m_tready <= ready_now;
    end
  end

  // every result beat taken is checked against the oldest owed sample
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_sample(m_tdata, m_tuser, m_tlast);
  end

  initial begin : stimulus
    logic [7:0]  corner_bytes [8];
    int unsigned waited;
    corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: fetch from an empty store, a partial 8x8 frame of corner bytes,
    // fetches into the partial frame, then restart it through the registers
    send_beat(CMD_FETCH, 8'hFF);
    foreach (corner_bytes[i]) send_beat(CMD_LOAD, corner_bytes[i]);
    send_beat(CMD_FETCH, 8'h00);
    send_beat(CMD_FETCH, 8'h5A);
    settle();
    write_reg(REG_WIDTH, 32'h0);          // zero is taken as one
    write_reg(REG_HEIGHT, 32'hFFFF_FFF0); // upper bits ignored, nibble zero

    // smallest frame in full: draining the last sample rearms the load
    run_frame(2, 1'b0);

    // fetches right after the drain find an empty store again
    repeat (4) send_beat(CMD_FETCH, 8'($urandom()));

    // wind down: wait for owed results, bounded, then a few more cycles
    s_tvalid <= 1'b0;
    waited = 0;
    while (sb.due_samples.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.due_samples.size() != 0) begin
      $error("%0d expected result beats never came", sb.due_samples.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
